FILE: hdl/fpa_pkg.sv
package fpa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned OpW      = 4;
  // dividend magnitude after the left shift
  localparam int unsigned DivW     = DataW + FracBits;
  // quotient bits settled per divider stage, and the stage count
  localparam int unsigned DivPer   = 4;
  localparam int unsigned DivSteps = (DivW + DivPer - 1) / DivPer;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_ITOF = 4'd8,
    OP_FTOI = 4'd9
  } op_e;

  // one divider stage: quotient bits settled, remainder, divisor magnitude, sign
  typedef struct packed {
    logic [DivW-1:0]  num;
    logic [DataW:0]   rem;
    logic [DataW-1:0] den;
    logic             neg;
  } div_t;

  // per-item sideband that rides the pipeline
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] res;
    logic             gt;
    logic             lt;
    logic             eq;
    logic             dz;
  } side_t;

endpackage

FILE: hdl/fpa_div.sv
// Restoring divider, one quotient bit per step, with a pipeline
// register after every group of bits. Moves with the top level's enable.
module fpa_div (
  input  logic                clk_i,
  input  logic                en_i,
  input  fpa_pkg::div_t       in_i,
  output logic [fpa_pkg::DataW-1:0] quo_o
);
  import fpa_pkg::*;

  localparam int unsigned Bits = DivW;

  div_t stg_q [DivSteps];
  div_t stg_d [DivSteps];

  // work DivPer bits between registers
  for (genvar s = 0; s < DivSteps; s++) begin : g_stage
    div_t src;

    if (s == 0) begin : g_first
      assign src = in_i;
    end else begin : g_next
      assign src = stg_q[s-1];
    end

    always_comb begin
      div_t w;
      logic [DataW:0] t;
      w = src;
      for (int k = 0; k < DivPer; k++) begin
        if (s * DivPer + k < Bits) begin
          t = {w.rem[DataW-1:0], w.num[Bits-1]};
          w.num = {w.num[Bits-2:0], 1'b0};
          if (t >= {1'b0, w.den}) begin
            w.rem = t - {1'b0, w.den};
            w.num[0] = 1'b1;
          end else begin
            w.rem = t;
          end
        end
      end
      stg_d[s] = w;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // apply sign and wrap
  always_comb begin
    logic [DataW-1:0] q;
    q = stg_q[DivSteps-1].num[DataW-1:0];
    quo_o = stg_q[DivSteps-1].neg ? (~q + 1'b1) : q;
  end

endmodule

FILE: hdl/fixed_point_alu_q24_8.sv
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, min, max, inc, dec and
// int/fixed conversion, with greater/less/equal flags on every item. Accepts
// one item per cycle while the output is not stalled; each item passes through
// the divider, which settles four quotient bits in each of its ten stages,
// and then through the output register.
// All ops travel through the same stages so results leave in order. A stall
// at the output freezes the whole pipeline; the output register holds.
module fixed_point_alu_q24_8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [fpa_pkg::OpW-1:0]   op_i,
  input  logic signed [fpa_pkg::DataW-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DataW-1:0] operand_b_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic signed [fpa_pkg::DataW-1:0] result_o,
  output logic        a_greater_o,
  output logic        a_less_o,
  output logic        a_equal_o,
  output logic        divide_by_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned Depth = DivSteps + 1;

  logic en;
  logic [Depth-1:0] vld_q;
  side_t side_q [Depth];
  side_t s0_d, s1_d, sl_d;
  div_t div_d;
  logic [DataW-1:0] quo;
  logic signed [2*DataW-1:0] prod_q, prod_d;

  // advance when the last slot is empty or being taken
  assign en      = ~vld_q[Depth-1] | ready_i;
  assign ready_o = en;

  // stage 0: decode, compare, simple ops, divider setup
  always_comb begin
    logic [DataW-1:0] ma, mb;
    ma = operand_a_i[DataW-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    mb = operand_b_i[DataW-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    s0_d.op  = op_i;
    s0_d.gt  = operand_a_i > operand_b_i;
    s0_d.lt  = operand_a_i < operand_b_i;
    s0_d.eq  = operand_a_i == operand_b_i;
    s0_d.dz  = (op_i == OP_DIV) && (operand_b_i == '0);
    case (op_i)
      OP_ADD:  s0_d.res = operand_a_i + operand_b_i;
      OP_SUB:  s0_d.res = operand_a_i - operand_b_i;
      OP_MIN:  s0_d.res = s0_d.lt ? operand_a_i : operand_b_i;
      OP_MAX:  s0_d.res = s0_d.gt ? operand_a_i : operand_b_i;
      OP_INC:  s0_d.res = operand_a_i + 1;
      OP_DEC:  s0_d.res = operand_a_i - 1;
      OP_ITOF: s0_d.res = operand_a_i << FracBits;
      OP_FTOI: s0_d.res = operand_a_i >>> FracBits;
      default: s0_d.res = '0;
    endcase
    div_d.num = {{FracBits{1'b0}}, ma} << FracBits;
    div_d.rem = '0;
    div_d.den = (mb == '0) ? DataW'(1) : mb;
    div_d.neg = operand_a_i[DataW-1] ^ operand_b_i[DataW-1];
    prod_d    = 64'(operand_a_i) * 64'(operand_b_i);
  end

  // finish mul in stage 1, div in the last stage
  always_comb begin
    s1_d = side_q[0];
    if (side_q[0].op == OP_MUL) begin
      s1_d.res = prod_q[FracBits +: DataW];
    end
    sl_d = side_q[Depth-2];
    if (side_q[Depth-2].op == OP_DIV && !side_q[Depth-2].dz) begin
      sl_d.res = quo;
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // advance sideband
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s0_d;
      prod_q    <= prod_d;
      side_q[1] <= s1_d;
      for (int i = 2; i < Depth - 1; i++) begin
        side_q[i] <= side_q[i-1];
      end
      side_q[Depth-1] <= sl_d;
    end
  end

  fpa_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (div_d),
    .quo_o (quo)
  );

  assign valid_o          = vld_q[Depth-1];
  assign result_o         = side_q[Depth-1].res;
  assign a_greater_o      = side_q[Depth-1].gt;
  assign a_less_o         = side_q[Depth-1].lt;
  assign a_equal_o        = side_q[Depth-1].eq;
  assign divide_by_zero_o = side_q[Depth-1].dz;

endmodule

FILE: hdl/fpa_checker.sv
module fpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        ready_i,
  input logic        ready_o,
  input logic        a_greater_o,
  input logic        a_less_o,
  input logic        a_equal_o,
  input logic        divide_by_zero_o,
  input logic [31:0] result_o
);

  // exactly one compare flag holds on a shown item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $onehot({a_greater_o, a_less_o, a_equal_o}))
    else $error("compare flags not exclusive");

  // a zero divisor gives a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && divide_by_zero_o |-> result_o == '0)
    else $error("divide by zero result not zero");

  // a waiting item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(result_o))
    else $error("output item dropped or changed");

  // input side opens whenever the output is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_i |-> ready_o)
    else $error("pipeline stalled with output taken");

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (.*);
